// ----- hw/rtl/dda_line_rasterizer_unit_assert.svh -----
// assertion macros for the line rasterizer
`ifndef DDA_LINE_RASTERIZER_UNIT_ASSERT_SVH
`define DDA_LINE_RASTERIZER_UNIT_ASSERT_SVH

// same-cycle implication, checked on every rising edge out of reset
`define DDA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define DDA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/dda_pkg.sv -----
// shared types and codes of the line rasterizer
`timescale 1ns / 1ps
`default_nettype none
package dda_pkg;

	localparam int COLOR_W = 24;

	localparam logic OP_START = 1'b0;
	localparam logic OP_STEP  = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SQ_X,
		ST_SQ_Y,
		ST_ROOT,
		ST_DIV_X,
		ST_DIV_Y
	} state_t;

endpackage
`default_nettype wire

// ----- hw/rtl/dda_line_rasterizer_unit.sv -----
// line rasterizer: start setup sequencer and per-pixel position stepping
//
// A start item (op 0) latches the end points and color, then the block is busy
// while it computes the pixel count floor(sqrt(dx*dx+dy*dy)) and the two
// fixed-point steps. One multiplier forms each axis square; the digit-by-digit
// square root and the restoring division per axis then run on one shared
// subtractor. A start item holds cmd_ready low through the squares, the root
// and both divisions, or through the squares and the root alone when the count
// is zero. A step item (op 1) emits one pixel through a single output register;
// outside setup, a step item that would emit waits only while that register is
// full and pixel_ready is low.
// A step item with no active line is taken and dropped.
`timescale 1ns / 1ps
`default_nettype none
`include "dda_line_rasterizer_unit_assert.svh"
module dda_line_rasterizer_unit #(
	parameter int COORD_BITS = 12,
	parameter int FRAC_BITS  = 16
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cmd_valid,
	output logic                              cmd_ready,
	input  wire logic                         op,
	input  wire logic [COORD_BITS-1:0]        begin_x,
	input  wire logic [COORD_BITS-1:0]        begin_y,
	input  wire logic [COORD_BITS-1:0]        end_x,
	input  wire logic [COORD_BITS-1:0]        end_y,
	input  wire logic [dda_pkg::COLOR_W-1:0]  color,
	output logic                              pixel_valid,
	input  wire logic                         pixel_ready,
	output logic [COORD_BITS-1:0]             pixel_x,
	output logic [COORD_BITS-1:0]             pixel_y,
	output logic [dda_pkg::COLOR_W-1:0]       pixel_color,
	output logic                              last
);

	localparam int POS_W      = COORD_BITS + FRAC_BITS;
	localparam int STEP_W     = FRAC_BITS + 2;
	localparam int CNT_W      = COORD_BITS + 1;
	localparam int QUO_W      = FRAC_BITS + 1;
	localparam int RAD_W      = 2 * COORD_BITS + 2;
	localparam int REM_W      = COORD_BITS + 4;
	localparam int ROOT_STEPS = COORD_BITS + 1;
	localparam int MAX_ITER   = (ROOT_STEPS > QUO_W) ? ROOT_STEPS : QUO_W;
	localparam int ITER_W     = $clog2(MAX_ITER + 1);

	dda_pkg::state_t state_q, state_d;

	logic [POS_W-1:0]            pos_x_q, pos_y_q;
	logic [STEP_W-1:0]           step_x_q, step_y_q;
	logic [CNT_W-1:0]            remaining_q;
	logic [dda_pkg::COLOR_W-1:0] line_color_q;
	logic [COORD_BITS-1:0]       mag_x_q, mag_y_q;
	logic                        neg_x_q, neg_y_q;
	logic [RAD_W-1:0]            rad_q;
	logic [REM_W-1:0]            rem_q;
	logic [CNT_W-1:0]            root_q;
	logic [QUO_W-1:0]            quo_q;
	logic [ITER_W-1:0]           iter_q;

	logic                        cmd_fire, start_fire, step_fire, pixel_fire;
	logic                        iter_done;
	logic [COORD_BITS-1:0]       mul_op;
	logic [2*COORD_BITS-1:0]     mul_prod;
	logic [REM_W-1:0]            sub_a, sub_b, rem_shift;
	logic [REM_W:0]              sub_diff;
	logic                        sub_ge;
	logic [CNT_W-1:0]            root_next;
	logic [QUO_W-1:0]            quo_next;
	logic [REM_W-1:0]            div_rem;
	logic [STEP_W-1:0]           step_mag, step_new;
	logic                        start_neg_x, start_neg_y;

	assign cmd_fire   = cmd_valid && cmd_ready;
	assign start_fire = cmd_fire && (op == dda_pkg::OP_START);
	assign step_fire  = cmd_fire && (op == dda_pkg::OP_STEP) && (remaining_q != '0);
	assign pixel_fire = pixel_valid && pixel_ready;

	assign start_neg_x = end_x < begin_x;
	assign start_neg_y = end_y < begin_y;

	// one multiplier, used once per axis
	assign mul_op   = (state_q == dda_pkg::ST_SQ_X) ? mag_x_q : mag_y_q;
	assign mul_prod = mul_op * mul_op;

	// shared subtractor: root trial in the square root, divisor in the divisions
	assign rem_shift = {rem_q[REM_W-3:0], rad_q[RAD_W-1 -: 2]};
	always_comb begin
		if (state_q == dda_pkg::ST_ROOT) begin
			sub_a = rem_shift;
			sub_b = REM_W'({root_q, 2'b01});
		end else begin
			sub_a = rem_q;
			sub_b = REM_W'(root_q);
		end
	end
	assign sub_diff = {1'b0, sub_a} - {1'b0, sub_b};
	assign sub_ge   = !sub_diff[REM_W];

	assign root_next = {root_q[CNT_W-2:0], sub_ge};
	assign quo_next  = {quo_q[QUO_W-2:0], sub_ge};
	assign div_rem   = sub_ge ? sub_diff[REM_W-1:0] : rem_q;

	assign iter_done = (state_q == dda_pkg::ST_ROOT) ?
		(iter_q == ITER_W'(ROOT_STEPS - 1)) : (iter_q == ITER_W'(QUO_W - 1));

	assign step_mag = {1'b0, quo_next};
	always_comb begin
		if (((state_q == dda_pkg::ST_DIV_X) && neg_x_q) ||
				((state_q == dda_pkg::ST_DIV_Y) && neg_y_q)) begin
			step_new = -step_mag;
		end else begin
			step_new = step_mag;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dda_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd_ready = 1'b0;
		unique case (state_q)
			dda_pkg::ST_IDLE: begin
				cmd_ready = (op == dda_pkg::OP_START) || (remaining_q == '0) ||
					!pixel_valid || pixel_ready;
				if (start_fire) begin
					state_d = dda_pkg::ST_SQ_X;
				end
			end
			dda_pkg::ST_SQ_X: begin
				state_d = dda_pkg::ST_SQ_Y;
			end
			dda_pkg::ST_SQ_Y: begin
				state_d = dda_pkg::ST_ROOT;
			end
			dda_pkg::ST_ROOT: begin
				if (iter_done) begin
					state_d = (root_next == '0) ? dda_pkg::ST_IDLE : dda_pkg::ST_DIV_X;
				end
			end
			dda_pkg::ST_DIV_X: begin
				if (iter_done) begin
					state_d = dda_pkg::ST_DIV_Y;
				end
			end
			dda_pkg::ST_DIV_Y: begin
				if (iter_done) begin
					state_d = dda_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = dda_pkg::ST_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			remaining_q <= '0;
			pixel_valid <= 1'b0;
		end else begin
			if (step_fire) begin
				pixel_valid <= 1'b1;
				remaining_q <= remaining_q - CNT_W'(1);
			end else if (pixel_fire) begin
				pixel_valid <= 1'b0;
			end
			if (state_q == dda_pkg::ST_ROOT && iter_done && root_next == '0) begin
				remaining_q <= '0;
			end
			if (state_q == dda_pkg::ST_DIV_Y && iter_done) begin
				remaining_q <= root_q;
			end
		end
	end

	// setup datapath, position and output payload
	always_ff @(posedge clk) begin
		if (start_fire) begin
			pos_x_q      <= {begin_x, {FRAC_BITS{1'b0}}};
			pos_y_q      <= {begin_y, {FRAC_BITS{1'b0}}};
			line_color_q <= color;
			neg_x_q      <= start_neg_x;
			neg_y_q      <= start_neg_y;
			mag_x_q      <= start_neg_x ? begin_x - end_x : end_x - begin_x;
			mag_y_q      <= start_neg_y ? begin_y - end_y : end_y - begin_y;
		end
		if (step_fire) begin
			pixel_x     <= pos_x_q[POS_W-1 -: COORD_BITS];
			pixel_y     <= pos_y_q[POS_W-1 -: COORD_BITS];
			pixel_color <= line_color_q;
			last        <= remaining_q == CNT_W'(1);
			pos_x_q     <= pos_x_q + {{(POS_W-STEP_W){step_x_q[STEP_W-1]}}, step_x_q};
			pos_y_q     <= pos_y_q + {{(POS_W-STEP_W){step_y_q[STEP_W-1]}}, step_y_q};
		end
		case (state_q)
			dda_pkg::ST_SQ_X: begin
				rad_q <= RAD_W'(mul_prod);
			end
			dda_pkg::ST_SQ_Y: begin
				rad_q  <= rad_q + RAD_W'(mul_prod);
				rem_q  <= '0;
				root_q <= '0;
				iter_q <= '0;
			end
			dda_pkg::ST_ROOT: begin
				rad_q  <= rad_q << 2;
				root_q <= root_next;
				if (iter_done) begin
					rem_q  <= REM_W'(mag_x_q);
					quo_q  <= '0;
					iter_q <= '0;
				end else begin
					rem_q  <= sub_ge ? sub_diff[REM_W-1:0] : rem_shift;
					iter_q <= iter_q + ITER_W'(1);
				end
			end
			dda_pkg::ST_DIV_X, dda_pkg::ST_DIV_Y: begin
				if (iter_done) begin
					if (state_q == dda_pkg::ST_DIV_X) begin
						step_x_q <= step_new;
						rem_q    <= REM_W'(mag_y_q);
					end else begin
						step_y_q <= step_new;
						rem_q    <= div_rem << 1;
					end
					quo_q  <= '0;
					iter_q <= '0;
				end else begin
					rem_q  <= div_rem << 1;
					quo_q  <= quo_next;
					iter_q <= iter_q + ITER_W'(1);
				end
			end
			default: begin
			end
		endcase
	end

	`DDA_ASSERT_NOW(a_busy_not_ready, state_q != dda_pkg::ST_IDLE, !cmd_ready,
		"command taken during line setup")
	`DDA_ASSERT_NEXT(a_step_emits, step_fire, pixel_valid,
		"step on an active line gave no pixel")
	`DDA_ASSERT_NEXT(a_count_loaded, (state_q == dda_pkg::ST_DIV_Y) && iter_done,
		(remaining_q == root_q) && (state_q == dda_pkg::ST_IDLE),
		"pixel count not loaded at end of setup")
	`DDA_ASSERT_NOW(a_div_rem_bound,
		(state_q == dda_pkg::ST_DIV_X) || (state_q == dda_pkg::ST_DIV_Y),
		rem_q < REM_W'({root_q, 1'b0}),
		"division remainder out of range")

endmodule
`default_nettype wire
